FILE: src/mpb_pkg.sv
// ----------------------------------------------------------------------------
// mpb_pkg
// Types, codes and lookup functions shared by the panel button controller.
// ----------------------------------------------------------------------------
package mpb_pkg;

    localparam int TpsW       = 10;
    localparam int CountW     = 10;
    localparam int TimeW      = 32;
    localparam int CfgIndexW  = 3;
    localparam int CfgDataW   = 16;
    localparam int InDataW    = 56;
    localparam int OutDataW   = 16;

    localparam logic [TimeW-1:0] UsPerMs  = 32'd1000;
    localparam logic [TimeW-1:0] UsPerS   = 32'd1000000;
    localparam logic [TimeW-1:0] UsPerMin = 32'd60000000;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_TICKS_PER_SECOND = 3'd0,
        CFG_LONG_PRESS_MS    = 3'd1,
        CFG_FAN_DELAY_S      = 3'd2,
        CFG_SLEEP_AFTER_MIN  = 3'd3,
        CFG_LIGHT_OFF_MIN    = 3'd4,
        CFG_MODE_FLAGS       = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2,
        EV_LED   = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_RUN     = 3'd1,
        ST_HOME    = 3'd2,
        ST_HOLD    = 3'd3,
        ST_ALARM   = 3'd4,
        ST_SLEEP   = 3'd5,
        ST_SUSPEND = 3'd6,
        ST_WAIT    = 3'd7
    } mstate_t;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_MANUAL_HALT = 3'd1,
        ACT_RELEASE     = 3'd2,
        ACT_RESET       = 3'd3,
        ACT_CLEAR_HALT  = 3'd4,
        ACT_SLEEP       = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        LIGHT_NONE = 2'd0,
        LIGHT_ON   = 2'd1,
        LIGHT_OFF  = 2'd2
    } light_t;

    localparam int ModeAutoSleep = 0;
    localparam int ModeLightOff  = 1;
    localparam int ModeLongSleep = 2;
    localparam int ModeCoverStop = 3;

    typedef struct packed {
        logic [TpsW-1:0]  ticks_per_second;
        logic [TimeW-1:0] long_limit;
        logic [TimeW-1:0] fan_limit;
        logic             sleep_en;
        logic [TimeW-1:0] sleep_limit;
        logic             light_en;
        logic [TimeW-1:0] light_limit;
        logic [3:0]       mode_flags;
    } cfg_t;

    typedef struct packed {
        logic             button_level;
        logic             estop_level;
        mstate_t          machine_state;
        logic             laser_mode;
        logic             suction_on;
        logic             probe_on;
        logic [7:0]       halt_code;
        logic             halted_flag;
        logic             job_playing;
        logic             lid_shut;
        logic [TimeW-1:0] now_us;
    } item_in_t;

    typedef struct packed {
        logic    fan_power;
        logic    main_power;
        logic    led_red;
        logic    led_green;
        logic    led_blue;
        logic    estop_halt;
        logic    cover_halt;
        logic    timeout_sleep;
        action_t press_action;
        light_t  light_command;
    } item_out_t;

    function automatic action_t press_code(mstate_t st, logic is_long, logic long_sleeps,
                                           logic [7:0] halt_code);
        action_t a;
        case (st)
            ST_IDLE:  a = is_long ? (long_sleeps ? ACT_SLEEP : ACT_NONE) : ACT_MANUAL_HALT;
            ST_RUN:   a = ACT_MANUAL_HALT;
            ST_HOME:  a = ACT_MANUAL_HALT;
            ST_HOLD:  a = ACT_RELEASE;
            ST_SLEEP: a = ACT_RESET;
            ST_ALARM: a = is_long ? ((halt_code > 8'd20) ? ACT_RESET : ACT_CLEAR_HALT)
                                  : ACT_NONE;
            default:  a = ACT_NONE;
        endcase
        return a;
    endfunction

    // bit0 red, bit1 green, bit2 blue
    function automatic logic [2:0] led_code(mstate_t st, logic b);
        logic [2:0] c;
        case (st)
            ST_IDLE:    c = 3'b100;
            ST_RUN:     c = 3'b010;
            ST_HOME:    c = 3'b011;
            ST_HOLD:    c = {1'b0, b, 1'b0};
            ST_ALARM:   c = 3'b001;
            ST_SLEEP:   c = 3'b111;
            ST_SUSPEND: c = {b, 2'b00};
            default:    c = {1'b0, b, b};
        endcase
        return c;
    endfunction

endpackage

FILE: src/mpb_cfg.sv
// ----------------------------------------------------------------------------
// mpb_cfg
// Configuration registers; timeout limits are scaled to microseconds on write.
// ----------------------------------------------------------------------------
module mpb_cfg
    import mpb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            case (cfg_index)
                CFG_TICKS_PER_SECOND: cfg_next.ticks_per_second = cfg_wdata[TpsW-1:0];
                CFG_LONG_PRESS_MS:
                    cfg_next.long_limit = TimeW'({16'd0, cfg_wdata} * UsPerMs);
                CFG_FAN_DELAY_S:
                    cfg_next.fan_limit = TimeW'({19'd0, cfg_wdata[12:0]} * UsPerS);
                CFG_SLEEP_AFTER_MIN: begin
                    cfg_next.sleep_en    = (cfg_wdata[6:0] != 7'd0);
                    cfg_next.sleep_limit = TimeW'({25'd0, cfg_wdata[6:0]} * UsPerMin);
                end
                CFG_LIGHT_OFF_MIN: begin
                    cfg_next.light_en    = (cfg_wdata[6:0] != 7'd0);
                    cfg_next.light_limit = TimeW'({25'd0, cfg_wdata[6:0]} * UsPerMin);
                end
                CFG_MODE_FLAGS: cfg_next.mode_flags = cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_second <= TpsW'(20);
            cfg_reg.long_limit       <= 32'd3000000;
            cfg_reg.fan_limit        <= 32'd30000000;
            cfg_reg.sleep_en         <= 1'b1;
            cfg_reg.sleep_limit      <= 32'd1800000000;
            cfg_reg.light_en         <= 1'b1;
            cfg_reg.light_limit      <= 32'd600000000;
            cfg_reg.mode_flags       <= 4'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/mpb_core.sv
// ----------------------------------------------------------------------------
// mpb_core
// Per-tick controller state and the single-pass logic that yields one result.
// ----------------------------------------------------------------------------
module mpb_core
    import mpb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      advance,
    input  item_in_t  item,
    output item_out_t result
);

    logic              estop_prev_reg, estop_prev_next;
    logic              held_reg, held_next;
    logic [TimeW-1:0]  press_start_reg, press_start_next;
    event_t            pending_reg, pending_next;
    logic [CountW-1:0] led_count_reg, led_count_next;
    logic [CountW-1:0] second_count_reg, second_count_next;
    logic [1:0]        blink_reg, blink_next;
    logic              draws_reg, draws_next;
    logic [TimeW-1:0]  fan_mark_reg, fan_mark_next;
    logic [TimeW-1:0]  sleep_mark_reg, sleep_mark_next;
    logic [TimeW-1:0]  light_mark_reg, light_mark_next;
    logic [1:0]        power_reg, power_next;
    logic [2:0]        led_reg, led_next;

    logic [CountW-1:0] sec_inc;
    logic [CountW-1:0] led_inc;
    logic [12:0]       led_scaled;
    logic              act;
    logic              loads;
    action_t           action;
    light_t            light;
    logic              tsleep;
    logic              cover_halt;

    always_comb begin
        estop_prev_next   = item.estop_level;
        held_next         = held_reg;
        press_start_next  = press_start_reg;
        pending_next      = pending_reg;
        led_count_next    = led_count_reg;
        blink_next        = blink_reg;
        draws_next        = draws_reg;
        fan_mark_next     = fan_mark_reg;
        sleep_mark_next   = sleep_mark_reg;
        light_mark_next   = light_mark_reg;
        power_next        = power_reg;
        led_next          = led_reg;
        action            = ACT_NONE;
        light             = LIGHT_NONE;
        tsleep            = 1'b0;
        cover_halt        = 1'b0;
        loads             = item.laser_mode | item.suction_on | item.probe_on;

        sec_inc = second_count_reg + CountW'(1);
        second_count_next = sec_inc;
        if (sec_inc >= cfg.ticks_per_second) begin
            second_count_next = '0;
            draws_next        = loads;
        end

        act = item.estop_level || (pending_reg != EV_NONE);
        if (act) begin
            cover_halt = cfg.mode_flags[ModeCoverStop] && !item.halted_flag
                         && item.job_playing && !item.lid_shut;

            if ((item.machine_state == ST_IDLE || item.machine_state == ST_SLEEP)
                && !draws_next) begin
                if ((item.now_us - fan_mark_reg) > cfg.fan_limit) begin
                    power_next[0] = 1'b0;
                end
            end else if (item.machine_state != ST_ALARM) begin
                power_next[0] = 1'b1;
                fan_mark_next = item.now_us;
            end

            if (cfg.mode_flags[ModeAutoSleep] && cfg.sleep_en) begin
                if (item.machine_state != ST_IDLE) begin
                    sleep_mark_next = item.now_us;
                end else if ((item.now_us - sleep_mark_reg) > cfg.sleep_limit) begin
                    power_next = 2'b00;
                    tsleep     = 1'b1;
                end
            end

            if (cfg.mode_flags[ModeLightOff] && cfg.light_en) begin
                if (item.machine_state != ST_IDLE) begin
                    light_mark_next = item.now_us;
                    light           = LIGHT_ON;
                end else if ((item.now_us - light_mark_reg) > cfg.light_limit) begin
                    light = LIGHT_OFF;
                end
            end

            if (pending_reg == EV_SHORT || pending_reg == EV_LONG) begin
                action = press_code(item.machine_state, pending_reg == EV_LONG,
                                    cfg.mode_flags[ModeLongSleep], item.halt_code);
                if (action == ACT_SLEEP) begin
                    power_next = 2'b00;
                end
            end else begin
                blink_next = blink_reg + 2'd1;
                led_next   = led_code(item.machine_state, ~blink_next[1]);
            end
            pending_next = EV_NONE;
        end

        led_inc    = led_count_reg + CountW'(1);
        led_scaled = {3'd0, led_inc} + {1'b0, led_inc, 2'b00};
        if (item.button_level) begin
            if (!held_reg) begin
                held_next        = 1'b1;
                press_start_next = item.now_us;
            end
        end else if (held_reg) begin
            pending_next = ((item.now_us - press_start_reg) > cfg.long_limit)
                           ? EV_LONG : EV_SHORT;
            held_next    = 1'b0;
        end else begin
            led_count_next = led_inc;
            if (led_scaled > {3'd0, cfg.ticks_per_second}) begin
                pending_next   = EV_LED;
                led_count_next = '0;
            end
        end

        result.fan_power     = power_next[0];
        result.main_power    = power_next[1];
        result.led_red       = led_next[0];
        result.led_green     = led_next[1];
        result.led_blue      = led_next[2];
        result.estop_halt    = item.estop_level && !estop_prev_reg;
        result.cover_halt    = cover_halt;
        result.timeout_sleep = tsleep;
        result.press_action  = action;
        result.light_command = light;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            estop_prev_reg   <= 1'b0;
            held_reg         <= 1'b0;
            press_start_reg  <= '0;
            pending_reg      <= EV_NONE;
            led_count_reg    <= '0;
            second_count_reg <= '0;
            blink_reg        <= '0;
            draws_reg        <= 1'b0;
            fan_mark_reg     <= '0;
            sleep_mark_reg   <= '0;
            light_mark_reg   <= '0;
            power_reg        <= 2'b11;
            led_reg          <= 3'b000;
        end else if (advance) begin
            estop_prev_reg   <= estop_prev_next;
            held_reg         <= held_next;
            press_start_reg  <= press_start_next;
            pending_reg      <= pending_next;
            led_count_reg    <= led_count_next;
            second_count_reg <= second_count_next;
            blink_reg        <= blink_next;
            draws_reg        <= draws_next;
            fan_mark_reg     <= fan_mark_next;
            sleep_mark_reg   <= sleep_mark_next;
            light_mark_reg   <= light_mark_next;
            power_reg        <= power_next;
            led_reg          <= led_next;
        end
    end

endmodule

FILE: src/machine_panel_button_controller.sv
// ----------------------------------------------------------------------------
// machine_panel_button_controller
// Panel button, power, status LED and idle timeout controller, one item a tick.
// ----------------------------------------------------------------------------
// Each input item is one poll tick and yields exactly one result item. An
// accepted item lands in an input register, passes the controller logic
// combinationally and is written into the result register, so a new item
// can be accepted every clock cycle while results keep flowing; m_tvalid
// rises when the item is written into the result register. While m_tready
// stays low the result register and the input register hold one item each,
// and s_tready then drops until the result is taken. The pending button or
// LED event taken from one tick is acted on at the next tick. Configuration
// writes must be made while no item is in flight.
// ----------------------------------------------------------------------------
module machine_panel_button_controller
    import mpb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] button_level, [1] estop_level, [4:2] machine_state, [5] laser_mode,
    // [6] suction_on, [7] probe_on, [15:8] halt_code, [16] halted_flag,
    // [17] job_playing, [18] lid_shut, [50:19] now_us, [55:51] zero
    input  logic [InDataW-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] fan_power, [1] main_power, [2] led_red, [3] led_green, [4] led_blue,
    // [5] estop_halt, [6] cover_halt, [7] timeout_sleep, [10:8] press_action,
    // [12:11] light_command, [15:13] zero
    output logic [OutDataW-1:0]  m_tdata
);

    cfg_t      cfg;
    item_in_t  in_reg;
    item_in_t  in_next;
    logic      in_valid_reg;
    item_out_t out_reg;
    item_out_t result;
    logic      out_valid_reg;
    logic      advance;

    mpb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mpb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (in_reg),
        .result  (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_next.button_level  = s_tdata[0];
        in_next.estop_level   = s_tdata[1];
        in_next.machine_state = mstate_t'(s_tdata[4:2]);
        in_next.laser_mode    = s_tdata[5];
        in_next.suction_on    = s_tdata[6];
        in_next.probe_on      = s_tdata[7];
        in_next.halt_code     = s_tdata[15:8];
        in_next.halted_flag   = s_tdata[16];
        in_next.job_playing   = s_tdata[17];
        in_next.lid_shut      = s_tdata[18];
        in_next.now_us        = s_tdata[50:19];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= in_next;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_reg.light_command,
                       out_reg.press_action,
                       out_reg.timeout_sleep,
                       out_reg.cover_halt,
                       out_reg.estop_halt,
                       out_reg.led_blue,
                       out_reg.led_green,
                       out_reg.led_red,
                       out_reg.main_power,
                       out_reg.fan_power};

endmodule

FILE: tb/sv/machine_panel_button_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// machine_panel_button_controller_test
// Self-checking bench for the panel button, power, LED and timeout controller.
// ----------------------------------------------------------------------------
// A short table of poll ticks walks reset behavior, e-stop edges, short and
// long presses in several machine states and timestamp extremes. Random phases
// follow under several register settings, extremes included: button presses
// of random length, sticky machine states and timestamps that advance by
// amounts from microseconds up to full wraps, with some fully random ticks.
// The sender works in bursts and the receiver stalls, once for a long
// stretch. Every result is compared field by field with a table value or with
// a predictor that keeps its own copy of the controller state.
// ----------------------------------------------------------------------------
module machine_panel_button_controller_test;
    import mpb_pkg::*;

    localparam int CycleLimit = 400000;

    typedef struct packed {
        item_in_t    tick;
        logic        typed;
        logic [15:0] want;
    } tick_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wen;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OutDataW-1:0]  m_tdata;

    // predicted controller state and registers
    logic        estop_was, btn_held, loads_on;
    logic [31:0] press_t0, fan_t0, sleep_t0, dark_t0;
    event_t      pend_ev;
    logic [9:0]  led_cnt, sec_cnt;
    logic [1:0]  blink;
    logic [1:0]  pwr;
    logic [2:0]  leds;
    logic [9:0]  cfg_tps;
    logic [15:0] cfg_long;
    logic [12:0] cfg_fan;
    logic [6:0]  cfg_sleep, cfg_dark;
    logic [3:0]  cfg_mode;

    logic [15:0] panel_due[$];
    int          miscompares = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          squeeze_req = 1'b0;

    // random stimulus shaping
    logic [31:0] rnd_now = 32'd0;
    logic        btn_lvl = 1'b0;
    logic        estop_cur = 1'b0;
    int          btn_run = 0;
    int          st_run = 0;
    mstate_t     st_cur = ST_IDLE;

    machine_panel_button_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("machine_panel_button_controller: mismatch");
            $finish;
        end
    end

    function automatic logic [InDataW-1:0] tick_word(item_in_t it);
        return {5'b00000, it.now_us, it.lid_shut, it.job_playing, it.halted_flag,
                it.halt_code, it.probe_on, it.suction_on, it.laser_mode,
                it.machine_state, it.estop_level, it.button_level};
    endfunction

    function automatic logic [15:0] panel_tick(item_in_t it);
        logic        estop_edge, cov, tsl, b;
        action_t     act;
        light_t      lt;
        event_t      ev;
        mstate_t     st;
        logic [31:0] fan_lim, sleep_lim, dark_lim, long_lim, now;
        ev  = pend_ev;
        st  = it.machine_state;
        now = it.now_us;
        fan_lim   = 32'(cfg_fan) * 32'd1000000;
        sleep_lim = 32'(cfg_sleep) * 32'd60000000;
        dark_lim  = 32'(cfg_dark) * 32'd60000000;
        long_lim  = 32'(cfg_long) * 32'd1000;
        cov = 1'b0;
        tsl = 1'b0;
        act = ACT_NONE;
        lt  = LIGHT_NONE;

        estop_edge = it.estop_level && !estop_was;
        estop_was  = it.estop_level;

        sec_cnt = sec_cnt + 10'd1;
        if (sec_cnt >= cfg_tps) begin
            sec_cnt  = 10'd0;
            loads_on = it.laser_mode | it.suction_on | it.probe_on;
        end

        if (it.estop_level || ev != EV_NONE) begin
            if (cfg_mode[ModeCoverStop] && !it.halted_flag && it.job_playing && !it.lid_shut)
                cov = 1'b1;

            if ((st == ST_IDLE || st == ST_SLEEP) && !loads_on) begin
                if (32'(now - fan_t0) > fan_lim) pwr[0] = 1'b0;
            end else if (st != ST_ALARM) begin
                pwr[0] = 1'b1;
                fan_t0 = now;
            end

            if (cfg_mode[ModeAutoSleep] && cfg_sleep != 7'd0) begin
                if (st != ST_IDLE) begin
                    sleep_t0 = now;
                end else if (32'(now - sleep_t0) > sleep_lim) begin
                    pwr = 2'b00;
                    tsl = 1'b1;
                end
            end
            if (cfg_mode[ModeLightOff] && cfg_dark != 7'd0) begin
                if (st != ST_IDLE) begin
                    dark_t0 = now;
                    lt = LIGHT_ON;
                end else if (32'(now - dark_t0) > dark_lim) begin
                    lt = LIGHT_OFF;
                end
            end

            if (ev == EV_SHORT || ev == EV_LONG) begin
                case (st)
                    ST_IDLE: begin
                        if (ev == EV_SHORT) act = ACT_MANUAL_HALT;
                        else if (cfg_mode[ModeLongSleep]) act = ACT_SLEEP;
                    end
                    ST_RUN, ST_HOME: act = ACT_MANUAL_HALT;
                    ST_HOLD: act = ACT_RELEASE;
                    ST_SLEEP: act = ACT_RESET;
                    ST_ALARM: begin
                        if (ev == EV_LONG) act = (it.halt_code > 8'd20) ? ACT_RESET : ACT_CLEAR_HALT;
                    end
                    default: act = ACT_NONE;
                endcase
                if (act == ACT_SLEEP) pwr = 2'b00;
            end else begin
                blink = blink + 2'd1;
                b = (blink < 2'd2);
                case (st)
                    ST_IDLE:    leds = 3'b100;
                    ST_RUN:     leds = 3'b010;
                    ST_HOME:    leds = 3'b011;
                    ST_HOLD:    leds = {1'b0, b, 1'b0};
                    ST_ALARM:   leds = 3'b001;
                    ST_SLEEP:   leds = 3'b111;
                    ST_SUSPEND: leds = {b, 2'b00};
                    default:    leds = {1'b0, b, b};
                endcase
            end
            pend_ev = EV_NONE;
        end

        if (it.button_level) begin
            if (!btn_held) begin
                btn_held = 1'b1;
                press_t0 = now;
            end
        end else if (btn_held) begin
            pend_ev  = (32'(now - press_t0) > long_lim) ? EV_LONG : EV_SHORT;
            btn_held = 1'b0;
        end else begin
            led_cnt = led_cnt + 10'd1;
            if (int'(led_cnt) * 5 > int'(cfg_tps)) begin
                pend_ev = EV_LED;
                led_cnt = 10'd0;
            end
        end

        return {3'b000, lt, act, tsl, cov, estop_edge, leds, pwr};
    endfunction

    function automatic tick_row_t tick_row(bit btn, bit estop, mstate_t st, bit [2:0] loads,
                                           bit [7:0] halt, bit [2:0] hpc, logic [31:0] now,
                                           bit typed = 1'b0, logic [15:0] want = 16'h0000);
        tick_row_t r;
        r.tick.button_level  = btn;
        r.tick.estop_level   = estop;
        r.tick.machine_state = st;
        r.tick.laser_mode    = loads[0];
        r.tick.suction_on    = loads[1];
        r.tick.probe_on      = loads[2];
        r.tick.halt_code     = halt;
        r.tick.halted_flag   = hpc[2];
        r.tick.job_playing   = hpc[1];
        r.tick.lid_shut      = hpc[0];
        r.tick.now_us        = now;
        r.typed              = typed;
        r.want               = want;
        return r;
    endfunction

    function automatic item_in_t next_poll_tick();
        item_in_t    it;
        logic [63:0] raw;
        int          pick;
        if (btn_run == 0) begin
            btn_lvl = ~btn_lvl;
            btn_run = btn_lvl ? $urandom_range(1, 6) : $urandom_range(1, 15);
        end
        btn_run--;
        if (st_run == 0) begin
            st_cur = mstate_t'($urandom_range(0, 7));
            if ($urandom_range(0, 2) == 0) st_cur = ST_IDLE;
            st_run = $urandom_range(1, 60);
        end
        st_run--;
        if ($urandom_range(0, 19) == 0) estop_cur = ~estop_cur;
        pick = $urandom_range(0, 99);
        if (pick < 50)      rnd_now = rnd_now + $urandom_range(0, 200000);
        else if (pick < 80) rnd_now = rnd_now + $urandom_range(0, 8000000);
        else if (pick < 95) rnd_now = rnd_now + $urandom_range(0, 1000000000);
        else                rnd_now = rnd_now + $urandom;

        it.button_level  = btn_lvl;
        it.estop_level   = estop_cur;
        it.machine_state = st_cur;
        it.laser_mode    = ($urandom_range(0, 3) == 0);
        it.suction_on    = ($urandom_range(0, 3) == 0);
        it.probe_on      = ($urandom_range(0, 3) == 0);
        it.halt_code     = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(15, 25));
        it.halted_flag   = 1'($urandom_range(0, 1));
        it.job_playing   = 1'($urandom_range(0, 1));
        it.lid_shut      = 1'($urandom_range(0, 1));
        it.now_us        = rnd_now;
        if ($urandom_range(0, 9) == 0) begin
            raw = {$urandom, $urandom};
            it  = raw[50:0];
        end
        return it;
    endfunction

    task automatic offer(item_in_t it, logic typed, logic [15:0] want);
        logic [15:0] predicted;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= tick_word(it);
        do @(posedge aclk); while (!s_tready);
        predicted = panel_tick(it);
        panel_due.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (panel_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cfg(input int tps, input int press_ms, input int fan_s,
                             input int sleep_min, input int dark_min, input int mode);
        logic [15:0] v;
        for (int i = 0; i <= 5; i++) begin
            case (cfg_index_t'(i))
                CFG_TICKS_PER_SECOND: begin v = 16'(tps);       cfg_tps   = v[9:0];  end
                CFG_LONG_PRESS_MS:    begin v = 16'(press_ms);  cfg_long  = v;       end
                CFG_FAN_DELAY_S:      begin v = 16'(fan_s);     cfg_fan   = v[12:0]; end
                CFG_SLEEP_AFTER_MIN:  begin v = 16'(sleep_min); cfg_sleep = v[6:0];  end
                CFG_LIGHT_OFF_MIN:    begin v = 16'(dark_min);  cfg_dark  = v[6:0];  end
                default:              begin v = 16'(mode);      cfg_mode  = v[3:0];  end
            endcase
            @(negedge aclk);
            cfg_wen   <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_wdata <= v;
        end
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic run_random(int count, bit squeeze);
        for (int n = 0; n < count; n++) begin
            if (squeeze && n == 60) squeeze_req = 1'b1;
            offer(next_poll_tick(), 1'b0, 16'h0000);
        end
        settle();
    endtask

    function automatic void field_span(input int f, output int lo, output int w,
                                       output string tag);
        case (f)
            0:       begin lo = 0;  w = 1; tag = "fan_power";     end
            1:       begin lo = 1;  w = 1; tag = "main_power";    end
            2:       begin lo = 2;  w = 1; tag = "led_red";       end
            3:       begin lo = 3;  w = 1; tag = "led_green";     end
            4:       begin lo = 4;  w = 1; tag = "led_blue";      end
            5:       begin lo = 5;  w = 1; tag = "estop_halt";    end
            6:       begin lo = 6;  w = 1; tag = "cover_halt";    end
            7:       begin lo = 7;  w = 1; tag = "timeout_sleep"; end
            8:       begin lo = 8;  w = 3; tag = "press_action";  end
            9:       begin lo = 11; w = 2; tag = "light_command"; end
            default: begin lo = 13; w = 3; tag = "padding";       end
        endcase
    endfunction

    always @(posedge aclk) begin : result_check
        logic [15:0] want, mask;
        int          lo, w;
        string       tag;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (panel_due.size() == 0) begin
                miscompares++;
                if (miscompares <= 10)
                    $display("result %0d: unexpected item %h", results_seen, m_tdata);
            end else begin
                want = panel_due.pop_front();
                for (int f = 0; f < 11; f++) begin
                    field_span(f, lo, w, tag);
                    mask = (16'd1 << w) - 16'd1;
                    if ((((want ^ m_tdata) >> lo) & mask) != 16'd0) begin
                        miscompares++;
                        if (miscompares <= 10)
                            $display("result %0d: %s expected %0d got %0d", results_seen, tag,
                                     (want >> lo) & mask, (m_tdata >> lo) & mask);
                    end
                end
            end
        end
    end

    initial begin : rx_side
        int  span, style;
        bit  squeezed;
        squeezed = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(20, 200);
            for (int k = 0; k < span; k++) begin
                @(negedge aclk);
                if (squeeze_req && !squeezed) begin
                    squeezed = 1'b1;
                    m_tready <= 1'b0;
                    repeat (400) @(negedge aclk);
                end
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (k % 5) < 3;
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        tick_row_t dir_ticks[25];
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wen   = 1'b0;
        cfg_index = CFG_TICKS_PER_SECOND;
        cfg_wdata = '0;

        estop_was = 1'b0;  btn_held = 1'b0;  loads_on = 1'b0;
        press_t0  = 32'd0; fan_t0   = 32'd0; sleep_t0 = 32'd0; dark_t0 = 32'd0;
        pend_ev   = EV_NONE;
        led_cnt   = 10'd0; sec_cnt  = 10'd0; blink    = 2'd0;
        pwr       = 2'b11; leds     = 3'b000;
        cfg_tps   = 10'd20; cfg_long = 16'd3000; cfg_fan = 13'd30;
        cfg_sleep = 7'd30;  cfg_dark = 7'd10;    cfg_mode = 4'd1;

        dir_ticks[0]  = tick_row(0, 0, ST_IDLE,    3'b000, 8'd0,   3'b000, 32'd0, 1, 16'h0003);
        dir_ticks[1]  = tick_row(0, 1, ST_IDLE,    3'b000, 8'd0,   3'b000, 32'd100, 1, 16'h0033);
        dir_ticks[2]  = tick_row(0, 1, ST_IDLE,    3'b000, 8'd0,   3'b000, 32'd200, 1, 16'h0013);
        dir_ticks[3]  = tick_row(1, 0, ST_IDLE,    3'b000, 8'd0,   3'b000, 32'd1000);
        dir_ticks[4]  = tick_row(0, 0, ST_IDLE,    3'b000, 8'd0,   3'b000, 32'd2000);
        dir_ticks[5]  = tick_row(0, 0, ST_RUN,     3'b111, 8'd0,   3'b000, 32'd3000);
        dir_ticks[6]  = tick_row(1, 0, ST_ALARM,   3'b000, 8'd255, 3'b100, 32'd10000);
        dir_ticks[7]  = tick_row(0, 0, ST_ALARM,   3'b000, 8'd255, 3'b100, 32'd4000000);
        dir_ticks[8]  = tick_row(0, 0, ST_ALARM,   3'b000, 8'd255, 3'b100, 32'd4001000);
        dir_ticks[9]  = tick_row(1, 0, ST_ALARM,   3'b000, 8'd20,  3'b100, 32'd5000000);
        dir_ticks[10] = tick_row(0, 0, ST_ALARM,   3'b000, 8'd20,  3'b100, 32'd9000000);
        dir_ticks[11] = tick_row(0, 0, ST_ALARM,   3'b000, 8'd20,  3'b100, 32'd9001000);
        dir_ticks[12] = tick_row(1, 0, ST_HOLD,    3'b001, 8'd0,   3'b000, 32'd9100000);
        dir_ticks[13] = tick_row(0, 0, ST_HOLD,    3'b010, 8'd0,   3'b000, 32'd9200000);
        dir_ticks[14] = tick_row(0, 0, ST_HOLD,    3'b100, 8'd0,   3'b000, 32'd9300000);
        dir_ticks[15] = tick_row(1, 0, ST_SLEEP,   3'b000, 8'd0,   3'b000, 32'd9400000);
        dir_ticks[16] = tick_row(0, 0, ST_SLEEP,   3'b000, 8'd0,   3'b000, 32'd9500000);
        dir_ticks[17] = tick_row(0, 0, ST_SLEEP,   3'b000, 8'd0,   3'b000, 32'd9600000);
        dir_ticks[18] = tick_row(1, 1, ST_WAIT,    3'b111, 8'd255, 3'b111, 32'hFFFF_FFFF);
        dir_ticks[19] = tick_row(0, 0, ST_SUSPEND, 3'b000, 8'd0,   3'b010, 32'd0);
        dir_ticks[20] = tick_row(0, 0, ST_SUSPEND, 3'b000, 8'd0,   3'b010, 32'd1000);
        dir_ticks[21] = tick_row(0, 1, ST_IDLE,    3'b000, 8'd0,   3'b010, 32'd40000000);
        dir_ticks[22] = tick_row(1, 0, ST_HOME,    3'b000, 8'd0,   3'b000, 32'd40001000);
        dir_ticks[23] = tick_row(0, 0, ST_HOME,    3'b000, 8'd0,   3'b000, 32'd40002000);
        dir_ticks[24] = tick_row(0, 0, ST_IDLE,    3'b000, 8'd0,   3'b000, 32'd2000000000);

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < 25; i++)
            offer(dir_ticks[i].tick, dir_ticks[i].typed, dir_ticks[i].want);
        settle();
        rnd_now = 32'd2000000000;

        run_random(350, 1'b1);
        write_cfg(1, 0, 0, 1, 1, 15);
        run_random(350, 1'b0);
        write_cfg(1000, 65535, 4294, 71, 71, 0);
        run_random(300, 1'b0);
        write_cfg(0, 1, 8191, 127, 127, 15);
        run_random(300, 1'b0);
        write_cfg($urandom_range(1, 30), $urandom_range(0, 4000), $urandom_range(0, 60),
                  $urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 15));
        run_random(450, 1'b0);

        repeat (10) @(posedge aclk);
        if (miscompares == 0) begin
            $display("machine_panel_button_controller: match");
        end else begin
            $display("machine_panel_button_controller: mismatch");
        end
        $finish;
    end

endmodule
